/* sv/mth_pkg.sv */
// ----------------------------------------------------------------------------
// mth_pkg
// Shared types, codes and the SipHash round for the tagged handle table.
// ----------------------------------------------------------------------------
package mth_pkg;

  localparam int TABLE_SLOTS_DEF = 1024;
  localparam int INDEX_BITS_DEF  = 16;

  // Width of one row of valid marks in the occupancy memory.
  localparam int ROW_W  = 32;
  localparam int ROW_BW = 5;

  localparam logic [1:0] OP_REGISTER = 2'd0;
  localparam logic [1:0] OP_LOOKUP   = 2'd1;
  localparam logic [1:0] OP_CLOSE    = 2'd2;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_FULL  = 3'd1;
  localparam logic [2:0] ST_RANGE = 3'd2;
  localparam logic [2:0] ST_EMPTY = 3'd3;
  localparam logic [2:0] ST_TAG   = 3'd4;

  localparam logic [0:0] CFG_KEY_LOW  = 1'b0;
  localparam logic [0:0] CFG_KEY_HIGH = 1'b1;

  localparam logic [63:0] SIP_C0 = 64'h736f6d6570736575;
  localparam logic [63:0] SIP_C1 = 64'h646f72616e646f6d;
  localparam logic [63:0] SIP_C2 = 64'h6c7967656e657261;
  localparam logic [63:0] SIP_C3 = 64'h7465646279746573;
  localparam logic [63:0] SIP_LEN12 = 64'h0c00_0000_0000_0000;
  localparam logic [63:0] SIP_FINAL = 64'h0000_0000_0000_00ff;

  typedef struct packed {
    logic [1:0]  op;
    logic        range_err;
    logic [63:0] handle;
    logic [63:0] obj;
  } cmd_t;

  typedef struct packed {
    logic [63:0] v0;
    logic [63:0] v1;
    logic [63:0] v2;
    logic [63:0] v3;
  } sip_state_t;

  function automatic logic [63:0] rotl(input logic [63:0] x, input int r);
    rotl = (x << r) | (x >> (64 - r));
  endfunction

  function automatic sip_state_t sip_round(input sip_state_t s);
    sip_state_t t;
    t = s;
    t.v0 = t.v0 + t.v1; t.v1 = rotl(t.v1, 13); t.v1 = t.v1 ^ t.v0; t.v0 = rotl(t.v0, 32);
    t.v2 = t.v2 + t.v3; t.v3 = rotl(t.v3, 16); t.v3 = t.v3 ^ t.v2;
    t.v0 = t.v0 + t.v3; t.v3 = rotl(t.v3, 21); t.v3 = t.v3 ^ t.v0;
    t.v2 = t.v2 + t.v1; t.v1 = rotl(t.v1, 17); t.v1 = t.v1 ^ t.v2; t.v2 = rotl(t.v2, 32);
    return t;
  endfunction

endpackage

/* sv/mth_front.sv */
// ----------------------------------------------------------------------------
// mth_front
// Takes input beats, checks the handle index range and holds decoded
// commands in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module mth_front #(
  parameter int TABLE_SLOTS = mth_pkg::TABLE_SLOTS_DEF,
  parameter int INDEX_BITS  = mth_pkg::INDEX_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_operation,
  input  logic [63:0]       in_handle_in,
  input  logic [63:0]       in_object_in,
  input  logic              busy_clear,
  output logic              q_valid,
  output mth_pkg::cmd_t     q_cmd,
  input  logic              q_pop
);

  mth_pkg::cmd_t q_mem_r [2];
  logic          wr_ptr_r;
  logic          rd_ptr_r;
  logic [1:0]    count_r;
  logic          push;
  logic          is_check;
  logic          out_of_range;
  mth_pkg::cmd_t cmd_in;

  assign in_stall = (count_r == 2'd2) || busy_clear;
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != 2'd0);
  assign q_cmd    = q_mem_r[rd_ptr_r];

  always_comb begin
    is_check     = (in_operation == mth_pkg::OP_LOOKUP) || (in_operation == mth_pkg::OP_CLOSE);
    out_of_range = 64'(in_handle_in[INDEX_BITS-1:0]) >= 64'(TABLE_SLOTS);
    cmd_in.op        = in_operation;
    cmd_in.range_err = is_check && out_of_range;
    cmd_in.handle    = in_handle_in;
    cmd_in.obj       = in_object_in;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (q_pop) rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + 2'(push) - 2'(q_pop);
    end
  end

endmodule

/* sv/mth_siphash.sv */
// ----------------------------------------------------------------------------
// mth_siphash
// Iterative SipHash-2-4 over a two-block message, one round per cycle.
// ----------------------------------------------------------------------------
module mth_siphash (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] key_low,
  input  logic [63:0] key_high,
  input  logic [63:0] msg0,
  input  logic [63:0] msg1,
  output logic        done,
  output logic [63:0] hash
);

  mth_pkg::sip_state_t v_r;
  mth_pkg::sip_state_t v_rnd;
  logic [63:0]         m0_r;
  logic [63:0]         m1_r;
  logic [2:0]          rnd_r;
  logic                busy_r;
  logic                done_r;
  logic [63:0]         hash_r;

  assign done = done_r;
  assign hash = hash_r;

  always_comb begin
    v_rnd = mth_pkg::sip_round(v_r);
    // Block boundaries fall after the second and fourth rounds.
    if (rnd_r == 3'd1) begin
      v_rnd.v0 = v_rnd.v0 ^ m0_r;
      v_rnd.v3 = v_rnd.v3 ^ m1_r;
    end else if (rnd_r == 3'd3) begin
      v_rnd.v0 = v_rnd.v0 ^ m1_r;
      v_rnd.v2 = v_rnd.v2 ^ mth_pkg::SIP_FINAL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      rnd_r  <= 3'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r   <= 1'b1;
        rnd_r    <= 3'd0;
        m0_r     <= msg0;
        m1_r     <= msg1;
        v_r.v0   <= key_low  ^ mth_pkg::SIP_C0;
        v_r.v1   <= key_high ^ mth_pkg::SIP_C1;
        v_r.v2   <= key_low  ^ mth_pkg::SIP_C2;
        v_r.v3   <= key_high ^ mth_pkg::SIP_C3 ^ msg0;
      end else if (busy_r) begin
        v_r   <= v_rnd;
        rnd_r <= rnd_r + 3'd1;
        if (rnd_r == 3'd7) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          hash_r <= v_rnd.v0 ^ v_rnd.v1 ^ v_rnd.v2 ^ v_rnd.v3;
        end
      end
    end
  end

endmodule

/* sv/mth_back.sv */
// ----------------------------------------------------------------------------
// mth_back
// Executes queued commands against the slot table: occupancy rows, tag and
// object memories, the nonce and the key registers.
// ----------------------------------------------------------------------------
module mth_back #(
  parameter int TABLE_SLOTS = mth_pkg::TABLE_SLOTS_DEF,
  parameter int INDEX_BITS  = mth_pkg::INDEX_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_write_en,
  input  logic [0:0]        cfg_index,
  input  logic [63:0]       cfg_data,
  input  logic              q_valid,
  input  mth_pkg::cmd_t     q_cmd,
  output logic              q_pop,
  output logic              busy_clear,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [63:0]       out_handle_out,
  output logic [63:0]       out_object_out,
  output logic [2:0]        out_status
);

  localparam int ROW_W   = mth_pkg::ROW_W;
  localparam int ROW_BW  = mth_pkg::ROW_BW;
  localparam int ROWS    = (TABLE_SLOTS + ROW_W - 1) / ROW_W;
  localparam int ROW_AW  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int SLOT_FW = ROW_AW + ROW_BW;
  localparam int SLOT_AW = $clog2(TABLE_SLOTS);
  localparam int TAG_BITS = 64 - INDEX_BITS;
  localparam logic [63:0] INDEX_MASK = (64'd1 << INDEX_BITS) - 64'd1;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_ISSUE, S_EVAL, S_HASH, S_RESULT
  } state_t;

  state_t              state_r;
  mth_pkg::cmd_t       cmd_r;
  logic [ROW_AW-1:0]   clr_cnt_r;
  logic [ROWS-1:0]     row_full_r;
  logic [63:0]         key_low_r;
  logic [63:0]         key_high_r;
  logic [63:0]         nonce_r;
  logic [ROW_AW-1:0]   reg_row_r;
  logic [SLOT_FW-1:0]  reg_slot_r;
  logic [ROW_W-1:0]    reg_row_data_r;
  logic                out_valid_r;
  logic [63:0]         handle_out_r;
  logic [63:0]         object_out_r;
  logic [2:0]          status_r;

  logic [ROW_W-1:0]    valid_mem [ROWS];
  logic [TAG_BITS-1:0] tag_mem [TABLE_SLOTS];
  logic [63:0]         obj_mem [TABLE_SLOTS];
  logic [ROW_W-1:0]    valid_rd_r;
  logic [TAG_BITS-1:0] tag_rd_r;
  logic [63:0]         obj_rd_r;

  logic                free_any;
  logic [ROW_AW-1:0]   free_row;
  logic [ROW_BW-1:0]   free_bit;
  logic [SLOT_FW-1:0]  chk_slot;
  logic [ROW_AW-1:0]   chk_row;
  logic [ROW_BW-1:0]   chk_bit;
  logic [ROW_AW-1:0]   rd_row;
  logic [ROW_W-1:0]    init_row;
  logic [ROW_W-1:0]    reg_new_row;
  logic                vm_we;
  logic [ROW_AW-1:0]   vm_addr;
  logic [ROW_W-1:0]    vm_data;
  logic                obj_we;
  logic                hash_start;
  logic                hash_done;
  logic [63:0]         hash;
  logic                chk_ok;
  logic                is_reg;

  assign busy_clear     = (state_r == S_CLEAR);
  assign q_pop          = (state_r == S_IDLE) && q_valid;
  assign out_valid      = out_valid_r;
  assign out_handle_out = handle_out_r;
  assign out_object_out = object_out_r;
  assign out_status     = status_r;

  // Lowest row with a free slot, then lowest free slot in that row.
  always_comb begin
    free_any = 1'b0;
    free_row = '0;
    for (int r = ROWS - 1; r >= 0; r--) begin
      if (!row_full_r[r]) begin
        free_any = 1'b1;
        free_row = ROW_AW'(r);
      end
    end
    free_bit = '0;
    for (int b = ROW_W - 1; b >= 0; b--) begin
      if (!valid_rd_r[b]) free_bit = ROW_BW'(b);
    end
  end

  always_comb begin
    chk_slot = SLOT_FW'(64'(cmd_r.handle[INDEX_BITS-1:0]));
    chk_row  = chk_slot[SLOT_FW-1:ROW_BW];
    chk_bit  = chk_slot[ROW_BW-1:0];
    is_reg   = (cmd_r.op == mth_pkg::OP_REGISTER);
    rd_row   = is_reg ? free_row : chk_row;
    // Padding past the last slot reads as occupied so it is never handed out.
    for (int b = 0; b < ROW_W; b++) begin
      init_row[b] = (SLOT_FW + 1)'({clr_cnt_r, ROW_BW'(b)}) >= (SLOT_FW + 1)'(TABLE_SLOTS);
    end
    reg_new_row = reg_row_data_r | (ROW_W'(1) << reg_slot_r[ROW_BW-1:0]);
    chk_ok = valid_rd_r[chk_bit] && (cmd_r.handle[63:INDEX_BITS] == tag_rd_r);
  end

  always_comb begin
    vm_we   = 1'b0;
    vm_addr = clr_cnt_r;
    vm_data = init_row;
    obj_we  = (state_r == S_HASH) && hash_done;
    case (state_r)
      S_CLEAR: begin
        vm_we = 1'b1;
      end
      S_EVAL: begin
        vm_we   = (cmd_r.op == mth_pkg::OP_CLOSE) && chk_ok;
        vm_addr = chk_row;
        vm_data = valid_rd_r & ~(ROW_W'(1) << chk_bit);
      end
      S_HASH: begin
        vm_we   = hash_done;
        vm_addr = reg_row_r;
        vm_data = reg_new_row;
      end
      default: begin
        vm_we = 1'b0;
      end
    endcase
    hash_start = (state_r == S_EVAL) && is_reg;
  end

  always_ff @(posedge clk) begin
    if (vm_we) valid_mem[vm_addr] <= vm_data;
    valid_rd_r <= valid_mem[rd_row];
  end

  always_ff @(posedge clk) begin
    if (obj_we) begin
      tag_mem[reg_slot_r[SLOT_AW-1:0]] <= hash[TAG_BITS-1:0];
      obj_mem[reg_slot_r[SLOT_AW-1:0]] <= cmd_r.obj;
    end
    tag_rd_r <= tag_mem[chk_slot[SLOT_AW-1:0]];
    obj_rd_r <= obj_mem[chk_slot[SLOT_AW-1:0]];
  end

  mth_siphash u_hash (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (hash_start),
    .key_low  (key_low_r),
    .key_high (key_high_r),
    .msg0     (nonce_r),
    .msg1     (64'({reg_row_r, free_bit}) | mth_pkg::SIP_LEN12),
    .done     (hash_done),
    .hash     (hash)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      row_full_r  <= '0;
      key_low_r   <= '0;
      key_high_r  <= '0;
      nonce_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        case (cfg_index)
          mth_pkg::CFG_KEY_LOW:  key_low_r  <= cfg_data;
          mth_pkg::CFG_KEY_HIGH: key_high_r <= cfg_data;
          default: key_low_r <= key_low_r;
        endcase
      end
      case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + ROW_AW'(1);
          if (32'(clr_cnt_r) == ROWS - 1) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (q_valid) begin
            cmd_r   <= q_cmd;
            state_r <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          handle_out_r <= '0;
          object_out_r <= '0;
          status_r     <= mth_pkg::ST_OK;
          reg_row_r    <= free_row;
          state_r      <= S_EVAL;
          if (cmd_r.range_err) begin
            status_r    <= mth_pkg::ST_RANGE;
            out_valid_r <= 1'b1;
            state_r     <= S_RESULT;
          end else if (is_reg && !free_any) begin
            status_r     <= mth_pkg::ST_FULL;
            handle_out_r <= 64'(TABLE_SLOTS);
            out_valid_r  <= 1'b1;
            state_r      <= S_RESULT;
          end else if (!is_reg && cmd_r.op != mth_pkg::OP_LOOKUP &&
                       cmd_r.op != mth_pkg::OP_CLOSE) begin
            out_valid_r <= 1'b1;
            state_r     <= S_RESULT;
          end
        end
        S_EVAL: begin
          if (is_reg) begin
            reg_slot_r     <= {reg_row_r, free_bit};
            reg_row_data_r <= valid_rd_r;
            state_r        <= S_HASH;
          end else begin
            if (!valid_rd_r[chk_bit]) begin
              status_r <= mth_pkg::ST_EMPTY;
            end else if (!chk_ok) begin
              status_r <= mth_pkg::ST_TAG;
            end else if (cmd_r.op == mth_pkg::OP_LOOKUP) begin
              object_out_r <= obj_rd_r;
            end else begin
              row_full_r[chk_row] <= 1'b0;
            end
            out_valid_r <= 1'b1;
            state_r     <= S_RESULT;
          end
        end
        S_HASH: begin
          if (hash_done) begin
            row_full_r[reg_row_r] <= &reg_new_row;
            nonce_r      <= nonce_r + 64'd1;
            handle_out_r <= (64'(reg_slot_r) & INDEX_MASK) |
                            (64'(hash[TAG_BITS-1:0]) << INDEX_BITS);
            out_valid_r  <= 1'b1;
            state_r      <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

/* sv/mac_tagged_handle_table.sv */
// ----------------------------------------------------------------------------
// mac_tagged_handle_table
// Handle table with SipHash-2-4 authenticated tags, top level.
// ----------------------------------------------------------------------------
// After reset the occupancy memory is swept, one row of 32 slots a cycle,
// over ceil(TABLE_SLOTS/32) rows (32 at the default size) while in_stall
// stays high; key writes are taken at any time. A register beat then waits
// on the tag hash, which runs its eight rounds one per cycle through a
// single round unit. Lookup and close pass through the issue and evaluate
// states, which wait on the registered reads of the slot memories. Beats
// are executed one at a time; a two-entry queue in front lets two more
// beats be taken while one is in progress or its result is stalled.
// ----------------------------------------------------------------------------
module mac_tagged_handle_table #(
  parameter int TABLE_SLOTS = mth_pkg::TABLE_SLOTS_DEF,
  parameter int INDEX_BITS  = mth_pkg::INDEX_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_write_en,
  input  logic [0:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [63:0] in_handle_in,
  input  logic [63:0] in_object_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_handle_out,
  output logic [63:0] out_object_out,
  output logic [2:0]  out_status
);

  logic          q_valid;
  logic          q_pop;
  logic          busy_clear;
  mth_pkg::cmd_t q_cmd;

  mth_front #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .INDEX_BITS  (INDEX_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_handle_in (in_handle_in),
    .in_object_in (in_object_in),
    .busy_clear   (busy_clear),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .q_pop        (q_pop)
  );

  mth_back #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .INDEX_BITS  (INDEX_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_write_en   (cfg_write_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .q_valid        (q_valid),
    .q_cmd          (q_cmd),
    .q_pop          (q_pop),
    .busy_clear     (busy_clear),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_handle_out (out_handle_out),
    .out_object_out (out_object_out),
    .out_status     (out_status)
  );

endmodule

/* sv/mth_checker.sv */
// ----------------------------------------------------------------------------
// mth_checker
// Port-level checks on the result channel of the handle table.
// ----------------------------------------------------------------------------
module mth_checker #(
  parameter int TABLE_SLOTS = mth_pkg::TABLE_SLOTS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] out_handle_out,
  input logic [63:0] out_object_out,
  input logic [2:0]  out_status
);

  // A stalled result beat keeps its payload.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_handle_out) &&
    $stable(out_object_out) && $stable(out_status))
    else $error("result beat changed while stalled");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= mth_pkg::ST_TAG)
    else $error("status code out of range");

  // A full table reports the slot count and no object.
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == mth_pkg::ST_FULL |->
    out_handle_out == 64'(TABLE_SLOTS) && out_object_out == 64'd0)
    else $error("full status with wrong payload");

  // Failed checks return nothing but the status.
  a_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == mth_pkg::ST_RANGE || out_status == mth_pkg::ST_EMPTY ||
    out_status == mth_pkg::ST_TAG) |-> out_handle_out == 64'd0 && out_object_out == 64'd0)
    else $error("failed check with nonzero payload");

endmodule

bind mac_tagged_handle_table mth_checker #(
  .TABLE_SLOTS (TABLE_SLOTS)
) u_mth_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_handle_out (out_handle_out),
  .out_object_out (out_object_out),
  .out_status     (out_status)
);

/* tb/sv/mac_tagged_handle_table_tb.sv */
// ----------------------------------------------------------------------------
// mac_tagged_handle_table_tb
// Self-checking bench for the SipHash-tagged handle table.
// A scoreboard keeps its own copy of the slots, keys and nonce. It predicts
// every result beat from the accepted input beats and compares the results
// field by field. The stimulus is a short directed set, then random mixes
// of well-formed and broken handles under several keys, then a pass that
// frees most live slots. Both sides idle at random, and the receiver holds
// off once for a long stretch.
// ----------------------------------------------------------------------------
module mac_tagged_handle_table_tb;

  localparam int          SLOTS      = 1024;
  localparam int          IDX_W      = 16;
  localparam logic [1:0]  OP_UNDEF   = 2'd3;
  localparam int          CYCLE_CAP  = 800000;
  localparam int          RAND_ITEMS = 520;

  class handle_table_scoreboard;
    bit [63:0] key_lo, key_hi, nonce;
    bit        slot_used [SLOTS];
    bit [47:0] slot_tag [SLOTS];
    bit [63:0] slot_obj [SLOTS];
    int        live_idx [$];
    bit [63:0] exp_handle [$];
    bit [63:0] exp_object [$];
    bit [2:0]  exp_status [$];
    int        errors, checked;

    function new();
      nonce = 0;
      key_lo = 0;
      key_hi = 0;
      errors = 0;
      checked = 0;
      foreach (slot_used[i]) slot_used[i] = 0;
    endfunction

    function bit [63:0] rol(bit [63:0] x, int r);
      return (x << r) | (x >> (64 - r));
    endfunction

    function void mix(ref bit [63:0] v0, v1, v2, v3);
      v0 += v1; v1 = rol(v1, 13); v1 ^= v0; v0 = rol(v0, 32);
      v2 += v3; v3 = rol(v3, 16); v3 ^= v2;
      v0 += v3; v3 = rol(v3, 21); v3 ^= v0;
      v2 += v1; v1 = rol(v1, 17); v1 ^= v2; v2 = rol(v2, 32);
    endfunction

    // Two message blocks: the nonce, then the slot index with the length byte.
    function bit [47:0] slot_mac(int idx, bit [63:0] n);
      bit [63:0] v0, v1, v2, v3, m;
      v0 = key_lo ^ 64'h736f6d6570736575;
      v1 = key_hi ^ 64'h646f72616e646f6d;
      v2 = key_lo ^ 64'h6c7967656e657261;
      v3 = key_hi ^ 64'h7465646279746573;
      for (int b = 0; b < 2; b++) begin
        m = (b == 0) ? n : (64'(idx) | (64'd12 << 56));
        v3 ^= m;
        mix(v0, v1, v2, v3);
        mix(v0, v1, v2, v3);
        v0 ^= m;
      end
      v2 ^= 64'hff;
      for (int r = 0; r < 4; r++) mix(v0, v1, v2, v3);
      return 48'(v0 ^ v1 ^ v2 ^ v3);
    endfunction

    function bit [2:0] vet(bit [63:0] h, output int idx);
      idx = int'(h[IDX_W-1:0]);
      if (h[IDX_W-1:0] >= SLOTS) return mth_pkg::ST_RANGE;
      if (!slot_used[idx]) return mth_pkg::ST_EMPTY;
      if (slot_tag[idx] != h[63:IDX_W]) return mth_pkg::ST_TAG;
      return mth_pkg::ST_OK;
    endfunction

    function bit live_handle(output bit [63:0] h);
      int i;
      if (live_idx.size() == 0) return 0;
      i = live_idx[$urandom_range(live_idx.size() - 1)];
      h = {slot_tag[i], 16'(i)};
      return 1;
    endfunction

    function void note_beat(bit [1:0] op, bit [63:0] h, bit [63:0] obj);
      bit [63:0] rh, ro;
      bit [2:0]  st;
      int        idx;
      rh = 0;
      ro = 0;
      st = mth_pkg::ST_OK;
      case (op)
        mth_pkg::OP_REGISTER: begin
          st = mth_pkg::ST_FULL;
          rh = 64'(SLOTS);
          for (int i = 0; i < SLOTS; i++) begin
            if (!slot_used[i]) begin
              slot_tag[i] = slot_mac(i, nonce);
              nonce += 1;
              slot_used[i] = 1;
              slot_obj[i] = obj;
              live_idx.push_back(i);
              rh = {slot_tag[i], 16'(i)};
              st = mth_pkg::ST_OK;
              break;
            end
          end
        end
        mth_pkg::OP_LOOKUP: begin
          st = vet(h, idx);
          if (st == mth_pkg::ST_OK) ro = slot_obj[idx];
        end
        mth_pkg::OP_CLOSE: begin
          st = vet(h, idx);
          if (st == mth_pkg::ST_OK) begin
            slot_used[idx] = 0;
            foreach (live_idx[k]) if (live_idx[k] == idx) begin
              live_idx.delete(k);
              break;
            end
          end
        end
        default: ;
      endcase
      exp_handle.push_back(rh);
      exp_object.push_back(ro);
      exp_status.push_back(st);
    endfunction

    task report(string what);
      errors++;
      $display("ERROR: %s", what);
    endtask

    task check_beat(bit [63:0] h, bit [63:0] obj, bit [2:0] st);
      bit [63:0] eh, eo;
      bit [2:0]  es;
      if (exp_status.size() == 0) begin
        report($sformatf("result beat with none expected: h=%h o=%h st=%0d", h, obj, st));
        return;
      end
      eh = exp_handle.pop_front();
      eo = exp_object.pop_front();
      es = exp_status.pop_front();
      checked++;
      if (h != eh) report($sformatf("beat %0d handle %h, want %h", checked, h, eh));
      if (obj != eo) report($sformatf("beat %0d object %h, want %h", checked, obj, eo));
      if (st != es) report($sformatf("beat %0d status %0d, want %0d", checked, st, es));
    endtask

    function int pending();
      return exp_status.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_write_en;
  logic [0:0]  cfg_index;
  logic [63:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_operation;
  logic [63:0] in_handle_in;
  logic [63:0] in_object_in;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] out_handle_out;
  logic [63:0] out_object_out;
  logic [2:0]  out_status;

  handle_table_scoreboard sb = new();
  bit quiet;
  bit hold_req;
  int cycles;

  mac_tagged_handle_table dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_operation(in_operation),
    .in_handle_in(in_handle_in), .in_object_in(in_object_in),
    .out_valid(out_valid), .out_stall(out_stall), .out_handle_out(out_handle_out),
    .out_object_out(out_object_out), .out_status(out_status)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_beat(out_handle_out, out_object_out, out_status);
  end

  // Receiver: random stall bursts, one long hold-off on request.
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 0;
        out_stall <= 1'b1;
        n = 0;
        while (n < 300) begin
          @(negedge clk);
          n++;
        end
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(12, 1)) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task send(bit [1:0] op, bit [63:0] h, bit [63:0] obj);
    @(negedge clk);
    in_valid <= 1'b1;
    in_operation <= op;
    in_handle_in <= h;
    in_object_in <= obj;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    sb.note_beat(op, h, obj);
  endtask

  task sender_gap();
    if (!quiet && $urandom_range(3) == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(12, 1) - 1) @(negedge clk);
    end
  endtask

  task drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task write_key(logic [0:0] idx, bit [63:0] val);
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write_en <= 1'b0;
    if (idx == mth_pkg::CFG_KEY_LOW) sb.key_lo = val;
    else sb.key_hi = val;
  endtask

  function bit [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Mostly valid handles with random objects; the rest are broken handles or undefined operations.
  task random_beat();
    bit [63:0] h;
    int        pick;
    pick = $urandom_range(99);
    if (pick < 40) begin
      send(mth_pkg::OP_REGISTER, rand64(), rand64());
    end else if (pick < 80 && sb.live_handle(h)) begin
      send(pick < 65 ? mth_pkg::OP_LOOKUP : mth_pkg::OP_CLOSE, h, rand64());
    end else if (pick < 86 && sb.live_handle(h)) begin
      h[63 - $urandom_range(47)] ^= 1'b1;
      send(pick[0] ? mth_pkg::OP_LOOKUP : mth_pkg::OP_CLOSE, h, rand64());
    end else if (pick < 90) begin
      send(pick[0] ? mth_pkg::OP_LOOKUP : mth_pkg::OP_CLOSE,
           {48'(rand64()), 16'($urandom_range(SLOTS - 1))}, rand64());
    end else if (pick < 94) begin
      send(OP_UNDEF, rand64(), rand64());
    end else begin
      send(2'($urandom_range(2, 1)), rand64(), rand64());
    end
  endtask

  initial begin
    bit [63:0] h0, h1;
    quiet = 0;
    hold_req = 0;
    rst_n = 1'b0;
    cfg_write_en = 1'b0;
    cfg_index = mth_pkg::CFG_KEY_LOW;
    cfg_data = '0;
    in_valid = 1'b0;
    in_operation = mth_pkg::OP_REGISTER;
    in_handle_in = '0;
    in_object_in = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: zero key first, then the edge cases of each operation.
    send(mth_pkg::OP_REGISTER, '0, '0);
    send(mth_pkg::OP_REGISTER, '1, '1);
    h0 = {sb.slot_tag[0], 16'd0};
    h1 = {sb.slot_tag[1], 16'd1};
    send(mth_pkg::OP_LOOKUP, h0, '0);
    send(mth_pkg::OP_LOOKUP, h1, '0);
    send(mth_pkg::OP_LOOKUP, h1 ^ (64'd1 << 63), '0);
    send(mth_pkg::OP_LOOKUP, h1 ^ (64'd1 << 16), '0);
    send(mth_pkg::OP_LOOKUP, 64'd5, '0);
    send(mth_pkg::OP_LOOKUP, 64'(SLOTS), '0);
    send(mth_pkg::OP_LOOKUP, '1, '0);
    send(mth_pkg::OP_CLOSE, 64'hffff, '0);
    send(mth_pkg::OP_LOOKUP, 64'(SLOTS - 1), '0);
    send(mth_pkg::OP_CLOSE, h0 ^ (64'd1 << 40), '0);
    send(mth_pkg::OP_CLOSE, h0, '0);
    send(mth_pkg::OP_CLOSE, h0, '0);
    send(mth_pkg::OP_LOOKUP, h0, '0);
    send(mth_pkg::OP_REGISTER, '0, 64'h0123456789abcdef);
    send(OP_UNDEF, '1, '1);
    send(OP_UNDEF, '0, '0);
    drain();

    write_key(mth_pkg::CFG_KEY_LOW, '1);
    write_key(mth_pkg::CFG_KEY_HIGH, '1);
    send(mth_pkg::OP_REGISTER, '0, 64'h8000000000000001);
    send(mth_pkg::OP_LOOKUP, {sb.slot_tag[2], 16'd2}, '0);
    drain();

    // Random phases, each under a different key.
    for (int p = 0; p < 4; p++) begin
      write_key(mth_pkg::CFG_KEY_LOW, p == 3 ? '0 : rand64());
      write_key(mth_pkg::CFG_KEY_HIGH, p == 0 ? '0 : rand64());
      for (int i = 0; i < RAND_ITEMS / 4; i++) begin
        if (p == 1 && i == 40) hold_req = 1;
        if (p == 2 && i == 60) begin
          @(negedge clk);
          in_valid <= 1'b0;
          while (sb.pending() > 0) @(posedge clk);
        end
        sender_gap();
        random_beat();
      end
      drain();
    end

    // Last pass, with no idling: free most of the live slots.
    write_key(mth_pkg::CFG_KEY_LOW, rand64());
    write_key(mth_pkg::CFG_KEY_HIGH, rand64());
    send(mth_pkg::OP_LOOKUP, {sb.slot_tag[SLOTS - 1], 16'(SLOTS - 1)}, '0);
    quiet = 1;
    for (int i = 0; i < 120; i++) begin
      if (i % 3 == 2) random_beat();
      else if (sb.live_handle(h0)) send(mth_pkg::OP_CLOSE, h0, '0);
    end
    drain();

    $display("Checked %0d result beats across several keys and random idling.", sb.checked);
    $display("Covered register, lookup, close, bad tags, empty and out-of-range slots.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
